/* hw/rtl/depth_pixel_backprojection_unit_assert.svh */
// Assertion macros shared by the back-projection RTL.
`ifndef DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH
`define DEPTH_PIXEL_BACKPROJECTION_UNIT_ASSERT_SVH
`ifndef SYNTH
// Check a condition in the same cycle as its trigger
`define DPB_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Check a condition in the cycle after its trigger
`define DPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DPB_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DPB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hw/rtl/dpb_pkg.sv */
package dpb_pkg;

   // Field and datapath widths
   localparam int COORD_W = 12;
   localparam int DEPTH_W = 16;
   localparam int COLOR_W = 8;
   localparam int CFG_W   = 16;
   localparam int DIFF_W  = COORD_W + 5;
   localparam int Z_W     = 20;
   localparam int NUM_W   = DIFF_W + Z_W;
   localparam int MAG_W   = NUM_W - 1;
   localparam int QUO_W   = 24;
   localparam int REM_W   = CFG_W;
   localparam int POS_W   = 24;
   localparam int PROD_W  = DEPTH_W + Z_W;
   localparam int SCALE_W = 30;
   localparam int TOP_W   = CFG_W + QUO_W;
   localparam int ADDR_W  = 4;
   localparam int REG_LSB = 2;
   localparam int DATA_W  = 32;

   // Depth scaling: z = round(depth * 65536 / 5000)
   // a0 = (depth * Z_RECIP) >> Z_SHIFT estimates depth * 8192 / 625 low by at most one.
   localparam logic [Z_W-1:0]     Z_RECIP     = 20'd858993;
   localparam int                 Z_SHIFT     = 16;
   localparam int                 DEPTH_SHIFT = 13;
   localparam logic [9:0]         Z_DIV       = 10'd625;
   localparam logic [10:0]        RND_ONE     = 11'd313;
   localparam logic [10:0]        RND_TWO     = 11'd938;
   localparam logic [Z_W-1:0]     Z_MAX       = 20'd858993;

   // Saturation bounds of the position outputs
   localparam logic [POS_W-1:0]   POS_MAX     = 24'h7FFFFF;
   localparam logic [POS_W-1:0]   POS_MIN     = 24'h800000;
   localparam logic [QUO_W-1:0]   NEG_MAG_MAX = 24'd8388608;

   // Register reset values
   localparam logic [CFG_W-1:0]   CENTER_COL_RST = 16'd5120;
   localparam logic [CFG_W-1:0]   CENTER_ROW_RST = 16'd3840;
   localparam logic [CFG_W-1:0]   FOCAL_COL_RST  = 16'd8448;
   localparam logic [CFG_W-1:0]   FOCAL_ROW_RST  = 16'd8448;

   typedef enum logic [ADDR_W-REG_LSB-1:0] {
      REG_CENTER_COL = 2'd0,
      REG_CENTER_ROW = 2'd1,
      REG_FOCAL_COL  = 2'd2,
      REG_FOCAL_ROW  = 2'd3
   } dpb_reg_type;

   // State of one divider cell: partial remainder, dividend bits still to
   // bring down, quotient bits so far, and per-axis flags.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] dvd;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             ovf;
      logic             nz;
   } dpb_cell_type;

   // Data that rides alongside the divider chain
   typedef struct packed {
      logic [Z_W-1:0]     z;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } dpb_side_type;

endpackage

/* hw/rtl/depth_pixel_backprojection_unit.sv */
// Depth pixel back-projection: one depth pixel in, one XYZRGB point out.
// Input channel (req_*): column, row, raw depth (0.2 mm units) and colour;
// a transaction is taken at a clock edge with req_valid high and req_stall low.
// Result channel (rsp_*): signed Q16 metre x/y saturated to 24 bits, Q16 z,
// colour, and a clipped flag; taken when rsp_valid is high and rsp_stall low.
// Camera registers (principal point, focal lengths in Q12.4 pixels) sit on
// the csr_* port at byte addresses 0, 4, 8, 12; write them while idle.
// Path: a taken input passes through the front stages of depth scaling and
// numerator set-up, a row of 24 divider cells per axis (one quotient bit per
// cell), and the output register.
// Throughput: one transaction per cycle while req_stall is low, set by the
// divider cell row, which moves every item one cell per cycle when enabled.
// Stall: while rsp_stall holds a result, the pipeline keeps moving as long as
// its last stage is empty; once an item waits there too, req_stall rises.
// Reset: synchronous; clears all valid bits and returns the camera
// registers to their defaults.
module depth_pixel_backprojection_unit import dpb_pkg::*; #(
   parameter int COORD_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [COORD_W-1:0]      req_col_index,
   input  logic [COORD_W-1:0]      req_row_index,
   input  logic [DEPTH_W-1:0]      req_depth_raw,
   input  logic [COLOR_W-1:0]      req_blue_in,
   input  logic [COLOR_W-1:0]      req_green_in,
   input  logic [COLOR_W-1:0]      req_red_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [POS_W-1:0] rsp_x_pos,
   output logic signed [POS_W-1:0] rsp_y_pos,
   output logic [Z_W-1:0]          rsp_z_pos,
   output logic [COLOR_W-1:0]      rsp_blue_out,
   output logic [COLOR_W-1:0]      rsp_green_out,
   output logic [COLOR_W-1:0]      rsp_red_out,
   output logic                    rsp_clipped,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [ADDR_W-1:0]       csr_paddr,
   input  logic [DATA_W-1:0]       csr_pwdata,
   output logic [DATA_W-1:0]       csr_prdata,
   output logic                    csr_pready
);

`include "depth_pixel_backprojection_unit_assert.svh"

   localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << COORD_BITS) - 1);

   typedef struct packed {
      logic [POS_W-1:0] pos;
      logic             clip;
   } axis_res_type;

   // Turn a quotient magnitude and its flags into a saturated position
   function automatic axis_res_type finish_axis(dpb_cell_type c);
      axis_res_type r;
      r.pos  = '0;
      r.clip = 1'b0;
      if (!c.nz) begin
         r.pos = '0;
      end else if (c.ovf) begin
         r.pos  = c.neg ? POS_MIN : POS_MAX;
         r.clip = 1'b1;
      end else if (!c.neg) begin
         if (c.quo[QUO_W-1]) begin
            r.pos  = POS_MAX;
            r.clip = 1'b1;
         end else begin
            r.pos = c.quo;
         end
      end else begin
         if (c.quo > NEG_MAG_MAX) begin
            r.pos  = POS_MIN;
            r.clip = 1'b1;
         end else begin
            r.pos = -c.quo;
         end
      end
      return r;
   endfunction

   logic [CFG_W-1:0] center_col_ff, center_row_ff, focal_col_ff, focal_row_ff;
   logic             csr_write;
   dpb_reg_type      csr_reg;

   logic             en;
   logic             out_take;
   logic             last_valid;
   logic             front_valid;
   dpb_cell_type     chain_x [0:QUO_W];
   dpb_cell_type     chain_y [0:QUO_W];
   dpb_side_type     front_side;
   logic [QUO_W-1:0] cell_valid_ff;
   dpb_side_type     side_ff [0:QUO_W-1];

   axis_res_type     res_x, res_y;
   logic             rsp_valid_ff;
   logic [POS_W-1:0] rsp_x_ff, rsp_y_ff;
   dpb_side_type     rsp_side_ff;
   logic             rsp_clip_ff;

   // Configuration registers
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = dpb_reg_type'(csr_paddr[ADDR_W-1:REG_LSB]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff <= CENTER_COL_RST;
         center_row_ff <= CENTER_ROW_RST;
         focal_col_ff  <= FOCAL_COL_RST;
         focal_row_ff  <= FOCAL_ROW_RST;
      end else if (csr_write) begin
         case (csr_reg)
            REG_CENTER_COL: center_col_ff <= csr_pwdata[CFG_W-1:0];
            REG_CENTER_ROW: center_row_ff <= csr_pwdata[CFG_W-1:0];
            REG_FOCAL_COL:  focal_col_ff  <= csr_pwdata[CFG_W-1:0];
            REG_FOCAL_ROW:  focal_row_ff  <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_CENTER_COL: csr_prdata = DATA_W'(center_col_ff);
         REG_CENTER_ROW: csr_prdata = DATA_W'(center_row_ff);
         REG_FOCAL_COL:  csr_prdata = DATA_W'(focal_col_ff);
         REG_FOCAL_ROW:  csr_prdata = DATA_W'(focal_row_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Advance the pipeline unless a finished item waits behind a held result
   assign last_valid = cell_valid_ff[QUO_W-1];
   assign out_take   = !rsp_valid_ff || !rsp_stall;
   assign en         = out_take || !last_valid;
   assign req_stall  = !en;

   dpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .col        (req_col_index & COORD_MASK),
      .row        (req_row_index & COORD_MASK),
      .depth      (req_depth_raw),
      .blue       (req_blue_in),
      .green      (req_green_in),
      .red        (req_red_in),
      .center_col (center_col_ff),
      .center_row (center_row_ff),
      .focal_col  (focal_col_ff),
      .focal_row  (focal_row_ff),
      .out_valid  (front_valid),
      .out_x      (chain_x[0]),
      .out_y      (chain_y[0]),
      .out_side   (front_side)
   );

   // One quotient bit per cell, most significant first
   for (genvar i = 0; i < QUO_W; i++) begin : g_cells
      dpb_cell u_cell_x (
         .clock    (clock),
         .en       (en),
         .focal    (focal_col_ff),
         .up_cell  (chain_x[i]),
         .cell_out (chain_x[i+1])
      );
      dpb_cell u_cell_y (
         .clock    (clock),
         .en       (en),
         .focal    (focal_row_ff),
         .up_cell  (chain_y[i]),
         .cell_out (chain_y[i+1])
      );
   end

   // Shift valid bits and side data alongside the cells
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_valid_ff <= '0;
      end else if (en) begin
         cell_valid_ff <= {cell_valid_ff[QUO_W-2:0], front_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= front_side;
         for (int i = 1; i < QUO_W; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Saturate and load the output register
   assign res_x = finish_axis(chain_x[QUO_W]);
   assign res_y = finish_axis(chain_y[QUO_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_take) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take && last_valid) begin
         rsp_x_ff    <= res_x.pos;
         rsp_y_ff    <= res_y.pos;
         rsp_side_ff <= side_ff[QUO_W-1];
         rsp_clip_ff <= res_x.clip || res_y.clip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_x_pos     = rsp_x_ff;
   assign rsp_y_pos     = rsp_y_ff;
   assign rsp_z_pos     = rsp_side_ff.z;
   assign rsp_blue_out  = rsp_side_ff.blue;
   assign rsp_green_out = rsp_side_ff.green;
   assign rsp_red_out   = rsp_side_ff.red;
   assign rsp_clipped   = rsp_clip_ff;

   logic x_at_bound, y_at_bound, origin;
   assign x_at_bound = (rsp_x_ff == POS_MAX) || (rsp_x_ff == POS_MIN);
   assign y_at_bound = (rsp_y_ff == POS_MAX) || (rsp_y_ff == POS_MIN);
   assign origin     = (rsp_x_ff == '0) && (rsp_y_ff == '0) && !rsp_clip_ff;

   `DPB_ASSERT_IMPL(a_zero_depth, clock, reset, rsp_valid && rsp_z_pos == '0, origin, "zero depth off origin")
   `DPB_ASSERT_IMPL(a_clip_bound, clock, reset, rsp_valid && rsp_clipped, x_at_bound || y_at_bound, "clip not at bound")
   `DPB_ASSERT_IMPL(a_z_range, clock, reset, rsp_valid, rsp_z_pos <= Z_MAX, "depth out of range")
   `DPB_ASSERT_NEXT(a_drain, clock, reset, last_valid && !req_stall, rsp_valid, "finished item lost")

endmodule

/* hw/rtl/dpb_front.sv */
module dpb_front import dpb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [COORD_W-1:0] col,
   input  logic [COORD_W-1:0] row,
   input  logic [DEPTH_W-1:0] depth,
   input  logic [COLOR_W-1:0] blue,
   input  logic [COLOR_W-1:0] green,
   input  logic [COLOR_W-1:0] red,
   input  logic [CFG_W-1:0]   center_col,
   input  logic [CFG_W-1:0]   center_row,
   input  logic [CFG_W-1:0]   focal_col,
   input  logic [CFG_W-1:0]   focal_row,
   output logic               out_valid,
   output dpb_cell_type       out_x,
   output dpb_cell_type       out_y,
   output dpb_side_type       out_side
);

   logic [4:0]               valid_ff;

   // Stage 1: reciprocal product and offsets from the principal point
   logic [PROD_W-1:0]        prod;
   logic [Z_W-1:0]           a0_in;
   logic signed [DIFF_W-1:0] dx1_in, dy1_in;
   dpb_side_type             side1_in;
   logic [DEPTH_W-1:0]       depth_ff;
   logic [Z_W-1:0]           a0_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;
   dpb_side_type             side1_ff;

   // Stage 2: correct the estimate and round
   logic [SCALE_W-1:0]       scaled;
   logic [SCALE_W-1:0]       a0_times;
   logic [SCALE_W-1:0]       rem_full;
   logic [10:0]              rem0;
   dpb_side_type             side2_in;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff;
   dpb_side_type             side2_ff;

   // Stage 3: numerators
   logic signed [NUM_W-1:0]  numx_in, numy_in;
   logic signed [NUM_W-1:0]  numx_ff, numy_ff;
   dpb_side_type             side3_ff;

   // Stage 4: sign and magnitude
   logic signed [NUM_W-1:0]  absx, absy;
   logic [MAG_W-1:0]         magx_ff, magy_ff;
   logic                     negx_ff, negy_ff, nzx_ff, nzy_ff;
   dpb_side_type             side4_ff;

   // Stage 5: range check and divider seed
   dpb_cell_type             x_in, y_in;
   dpb_cell_type             x_ff, y_ff;
   dpb_side_type             side5_ff;

   always_comb begin
      prod           = PROD_W'(depth) * PROD_W'(Z_RECIP);
      a0_in          = prod[PROD_W-1:Z_SHIFT];
      dx1_in         = $signed({1'b0, col, 4'b0}) - $signed({1'b0, center_col});
      dy1_in         = $signed({1'b0, row, 4'b0}) - $signed({1'b0, center_row});
      side1_in.z     = '0;
      side1_in.blue  = blue;
      side1_in.green = green;
      side1_in.red   = red;
   end

   always_comb begin
      scaled     = {1'b0, depth_ff, {DEPTH_SHIFT{1'b0}}};
      a0_times   = SCALE_W'(a0_ff) * SCALE_W'(Z_DIV);
      rem_full   = scaled - a0_times;
      rem0       = rem_full[10:0];
      side2_in   = side1_ff;
      side2_in.z = a0_ff + Z_W'(rem0 >= RND_ONE) + Z_W'(rem0 >= RND_TWO);
   end

   assign numx_in = dx2_ff * $signed({1'b0, side2_ff.z});
   assign numy_in = dy2_ff * $signed({1'b0, side2_ff.z});

   assign absx = numx_ff[NUM_W-1] ? -numx_ff : numx_ff;
   assign absy = numy_ff[NUM_W-1] ? -numy_ff : numy_ff;

   // Seed each divider: top dividend bits become the first remainder
   always_comb begin
      x_in.rem = REM_W'(magx_ff[MAG_W-1:QUO_W]);
      x_in.dvd = magx_ff[QUO_W-1:0];
      x_in.quo = '0;
      x_in.neg = negx_ff;
      x_in.nz  = nzx_ff;
      x_in.ovf = nzx_ff && ({{(TOP_W-MAG_W){1'b0}}, magx_ff} >= {focal_col, {QUO_W{1'b0}}});
      y_in.rem = REM_W'(magy_ff[MAG_W-1:QUO_W]);
      y_in.dvd = magy_ff[QUO_W-1:0];
      y_in.quo = '0;
      y_in.neg = negy_ff;
      y_in.nz  = nzy_ff;
      y_in.ovf = nzy_ff && ({{(TOP_W-MAG_W){1'b0}}, magy_ff} >= {focal_row, {QUO_W{1'b0}}});
   end

   // Advance stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // Advance stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         depth_ff <= depth;
         a0_ff    <= a0_in;
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         side1_ff <= side1_in;
         dx2_ff   <= dx1_ff;
         dy2_ff   <= dy1_ff;
         side2_ff <= side2_in;
         numx_ff  <= numx_in;
         numy_ff  <= numy_in;
         side3_ff <= side2_ff;
         magx_ff  <= absx[MAG_W-1:0];
         magy_ff  <= absy[MAG_W-1:0];
         negx_ff  <= numx_ff[NUM_W-1];
         negy_ff  <= numy_ff[NUM_W-1];
         nzx_ff   <= (numx_ff != '0);
         nzy_ff   <= (numy_ff != '0);
         side4_ff <= side3_ff;
         x_ff     <= x_in;
         y_ff     <= y_in;
         side5_ff <= side4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_side  = side5_ff;

endmodule

/* hw/rtl/dpb_cell.sv */
module dpb_cell import dpb_pkg::*; (
   input  logic             clock,
   input  logic             en,
   input  logic [CFG_W-1:0] focal,
   input  dpb_cell_type     up_cell,
   output dpb_cell_type     cell_out
);

   logic [REM_W:0] trial;
   logic [REM_W:0] diff;
   logic           ge;
   dpb_cell_type   cell_in;
   dpb_cell_type   cell_ff;

   // Bring down one dividend bit and try the subtraction
   always_comb begin
      trial       = {up_cell.rem, up_cell.dvd[QUO_W-1]};
      diff        = trial - {1'b0, focal};
      ge          = (trial >= {1'b0, focal});
      cell_in     = up_cell;
      cell_in.rem = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      cell_in.dvd = {up_cell.dvd[QUO_W-2:0], 1'b0};
      cell_in.quo = {up_cell.quo[QUO_W-2:0], ge};
   end

   // Hand the result to the next cell
   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_out = cell_ff;

endmodule

/* dv/depth_pixel_backprojection_unit_test.sv */
module depth_pixel_backprojection_unit_test;
   import dpb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Pixel coordinate bits that the unit uses, and the point format bounds
   localparam int     PIX_BITS       = 12;
   localparam longint PIX_MASK       = (longint'(1) << PIX_BITS) - 1;
   localparam longint DEPTH_SCALE    = 5000;
   localparam longint DEPTH_ROUND    = DEPTH_SCALE / 2;
   localparam longint POS_HIGH       = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_LOW        = -(longint'(1) << (POS_W - 1));
   localparam int     RGB_W          = 3 * COLOR_W;
   localparam int     SETTLE_CYCLES  = 40;
   localparam int     HOLD_OFF_CYCLES = 400;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     MAX_PRINTED    = 50;

   typedef struct packed {
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [DEPTH_W-1:0] depth;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      logic [POS_W-1:0]   x;
      logic [POS_W-1:0]   y;
      logic [Z_W-1:0]     z;
      logic [COLOR_W-1:0] blue;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic               clipped;
   } point_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [COORD_W-1:0]      req_col_index = '0;
   logic [COORD_W-1:0]      req_row_index = '0;
   logic [DEPTH_W-1:0]      req_depth_raw = '0;
   logic [COLOR_W-1:0]      req_blue_in = '0;
   logic [COLOR_W-1:0]      req_green_in = '0;
   logic [COLOR_W-1:0]      req_red_in = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [POS_W-1:0] rsp_x_pos;
   logic signed [POS_W-1:0] rsp_y_pos;
   logic [Z_W-1:0]          rsp_z_pos;
   logic [COLOR_W-1:0]      rsp_blue_out;
   logic [COLOR_W-1:0]      rsp_green_out;
   logic [COLOR_W-1:0]      rsp_red_out;
   logic                    rsp_clipped;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]       csr_paddr = '0;
   logic [DATA_W-1:0]       csr_pwdata = '0;
   logic [DATA_W-1:0]       csr_prdata;
   logic                    csr_pready;

   // Camera registers as the unit should hold them
   logic [CFG_W-1:0] camera_reg [4];

   pixel_type pixel_backlog [$];
   point_type pending_points [$];

   bit in_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_seg_left = 0;
   int stall_pct = 0;
   int hold_off_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int pixels_queued = 0;
   int pixels_taken = 0;
   int points_received = 0;
   int clipped_points = 0;
   int zero_depth_points = 0;
   int input_held_cycles = 0;
   int camera_settings = 1;

   depth_pixel_backprojection_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_col_index (req_col_index),
      .req_row_index (req_row_index),
      .req_depth_raw (req_depth_raw),
      .req_blue_in   (req_blue_in),
      .req_green_in  (req_green_in),
      .req_red_in    (req_red_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_pos     (rsp_x_pos),
      .rsp_y_pos     (rsp_y_pos),
      .rsp_z_pos     (rsp_z_pos),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out),
      .rsp_clipped   (rsp_clipped),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #1 clock = ~clock;

   // Project one pixel coordinate onto its metric axis, saturating to the
   // point format; a zero focal length saturates toward the numerator sign
   function automatic logic [POS_W-1:0] axis_offset(logic [COORD_W-1:0] pix,
                                                    logic [CFG_W-1:0] center,
                                                    logic [CFG_W-1:0] focal,
                                                    longint zq,
                                                    inout logic clip);
      longint coord, ctr, fl, num, quo;
      coord = pix;
      coord = coord & PIX_MASK;
      ctr = center;
      fl = focal;
      num = (coord * 16 - ctr) * zq;
      if (fl == 0) begin
         if (num == 0)
            return '0;
         clip = 1'b1;
         return (num > 0) ? POS_W'(POS_HIGH) : POS_W'(POS_LOW);
      end
      quo = num / fl;
      if (quo > POS_HIGH) begin
         clip = 1'b1;
         return POS_W'(POS_HIGH);
      end
      if (quo < POS_LOW) begin
         clip = 1'b1;
         return POS_W'(POS_LOW);
      end
      return POS_W'(quo);
   endfunction

   // Back-project one depth pixel to its coloured point
   function automatic point_type backproject(pixel_type px);
      point_type pt;
      logic clip;
      longint zq;
      pt = '0;
      clip = 1'b0;
      zq = 0;
      if (px.depth != 0) begin
         zq = (longint'(px.depth) * 65536 + DEPTH_ROUND) / DEPTH_SCALE;
         pt.x = axis_offset(px.col, camera_reg[REG_CENTER_COL], camera_reg[REG_FOCAL_COL],
                            zq, clip);
         pt.y = axis_offset(px.row, camera_reg[REG_CENTER_ROW], camera_reg[REG_FOCAL_ROW],
                            zq, clip);
      end
      pt.z = Z_W'(zq);
      pt.blue = px.blue;
      pt.green = px.green;
      pt.red = px.red;
      pt.clipped = clip;
      return pt;
   endfunction

   // Pick a coordinate: image edges, near the principal point, or anywhere
   function automatic logic [COORD_W-1:0] random_coord(logic [CFG_W-1:0] center);
      int pick;
      int c;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         return ($urandom_range(0, 1) != 0) ? {COORD_W{1'b1}} : '0;
      if (pick < 25) begin
         c = int'(center >> 4) + $urandom_range(0, 2) - 1;
         if (c < 0)
            c = 0;
         if (c > int'(PIX_MASK))
            c = int'(PIX_MASK);
         return COORD_W'(c);
      end
      return COORD_W'($urandom());
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type px;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8)
         px.depth = '0;
      else if (pick < 25)
         px.depth = DEPTH_W'($urandom_range(1, 20));
      else if (pick < 35)
         px.depth = {DEPTH_W{1'b1}} - DEPTH_W'($urandom_range(0, 3));
      else
         px.depth = DEPTH_W'($urandom_range(1, 65535));
      px.col = random_coord(camera_reg[REG_CENTER_COL]);
      px.row = random_coord(camera_reg[REG_CENTER_ROW]);
      {px.blue, px.green, px.red} = RGB_W'($urandom());
      return px;
   endfunction

   task automatic queue_pixel(int col, int row, int depth, logic [3*COLOR_W-1:0] rgb);
      pixel_type px;
      px.col = COORD_W'(col);
      px.row = COORD_W'(row);
      px.depth = DEPTH_W'(depth);
      {px.blue, px.green, px.red} = rgb;
      pixel_backlog.push_back(px);
      pixels_queued++;
   endtask

   task automatic queue_random(int count);
      repeat (count) begin
         pixel_backlog.push_back(random_pixel());
         pixels_queued++;
      end
   endtask

   task automatic report_mismatch(string what, logic signed [63:0] got,
                                  logic signed [63:0] want);
      if (mismatches < MAX_PRINTED)
         $display("mismatch at point %0d: %s got %0d, expected %0d",
                  points_received, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(string what, logic signed [63:0] got, logic signed [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Write one camera register, then read it back; call at a falling edge
   task automatic write_camera_reg(dpb_reg_type idx, logic [CFG_W-1:0] value);
      logic [DATA_W-1:0] rd;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, {REG_LSB{1'b0}}};
      csr_pwdata <= DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      camera_reg[idx] = value;
      @(negedge clock);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      check_field(idx.name(), rd, DATA_W'(value));
   endtask

   task automatic program_camera(int ccol, int crow, int fcol, int frow);
      write_camera_reg(REG_CENTER_COL, CFG_W'(ccol));
      write_camera_reg(REG_CENTER_ROW, CFG_W'(crow));
      write_camera_reg(REG_FOCAL_COL, CFG_W'(fcol));
      write_camera_reg(REG_FOCAL_ROW, CFG_W'(frow));
      camera_settings++;
   endtask

   // Wait at falling edges until every queued pixel has come back as a point
   task automatic wait_drained();
      while (points_received < pixels_queued)
         @(negedge clock);
   endtask

   // Sender: bursts of random length with random gaps, payload held while stalled
   always @(negedge clock) begin
      pixel_type px;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_backlog.size() > 0) begin
            px = pixel_backlog.pop_front();
            req_col_index <= px.col;
            req_row_index <= px.row;
            req_depth_raw <= px.depth;
            req_blue_in <= px.blue;
            req_green_in <= px.green;
            req_red_in <= px.red;
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall density changes per segment; a long hold-off on request
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (stall_seg_left == 0) begin
            stall_seg_left = $urandom_range(4, 60);
            case ($urandom_range(0, 3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end else begin
            stall_seg_left--;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Monitor: predict each accepted pixel, check each accepted point
   always @(posedge clock) begin
      pixel_type px;
      point_type want;
      if (reset) begin
         in_taken = 1'b0;
      end else begin
         in_taken = req_valid && !req_stall;
         if (req_valid && req_stall)
            input_held_cycles++;
         if (in_taken) begin
            px = '{req_col_index, req_row_index, req_depth_raw,
                   req_blue_in, req_green_in, req_red_in};
            want = backproject(px);
            pending_points.push_back(want);
            pixels_taken++;
            if (want.clipped)
               clipped_points++;
            if (px.depth == 0)
               zero_depth_points++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_points.size() == 0) begin
               report_mismatch("point with no pixel pending", 0, 0);
            end else begin
               want = pending_points.pop_front();
               check_field("x_pos", rsp_x_pos, $signed(want.x));
               check_field("y_pos", rsp_y_pos, $signed(want.y));
               check_field("z_pos", rsp_z_pos, want.z);
               check_field("blue_out", rsp_blue_out, want.blue);
               check_field("green_out", rsp_green_out, want.green);
               check_field("red_out", rsp_red_out, want.red);
               check_field("clipped", rsp_clipped, want.clipped);
            end
            points_received++;
         end
         if (in_taken || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT)
         @(negedge clock);
      $display("watchdog: no transaction for %0d cycles, %0d points outstanding",
               WATCHDOG_LIMIT, pending_points.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus sequence
   initial begin
      camera_reg[REG_CENTER_COL] = CENTER_COL_RST;
      camera_reg[REG_CENTER_ROW] = CENTER_ROW_RST;
      camera_reg[REG_FOCAL_COL] = FOCAL_COL_RST;
      camera_reg[REG_FOCAL_ROW] = FOCAL_ROW_RST;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Defaults after reset: field extremes, zero depth, zero numerator
      queue_pixel(0, 0, 0, 24'h000000);
      queue_pixel(4095, 4095, 0, 24'hFFFFFF);
      queue_pixel(0, 0, 1, 24'hA55A3C);
      queue_pixel(4095, 4095, 65535, 24'hFF00FF);
      queue_pixel(0, 0, 65535, 24'h00FF00);
      queue_pixel(320, 240, 65535, 24'h123456);
      queue_pixel(320, 0, 5000, 24'h0F0F0F);
      queue_pixel(0, 240, 2, 24'hF0F0F0);
      queue_pixel(4095, 0, 30000, 24'h808080);
      queue_pixel(0, 4095, 12345, 24'h7F7F7F);
      queue_pixel(1, 1, 3, 24'h010203);
      queue_pixel(2048, 2048, 32768, 24'hFEDCBA);
      queue_pixel(2730, 1365, 43690, 24'hAA55AA);
      queue_pixel(1365, 2730, 21845, 24'h55AA55);
      queue_pixel(321, 239, 4, 24'h000001);
      queue_pixel(319, 241, 5, 24'h800000);
      queue_random(150);
      wait_drained();

      // Typical camera; hold the receiver off so the pipeline backs up
      program_camera(5112, 3832, 8400, 8400);
      queue_random(200);
      @(posedge clock);
      hold_off_left = HOLD_OFF_CYCLES;
      @(negedge clock);
      wait_drained();

      // Principal point at the origin, widest focal length
      program_camera(0, 0, 65535, 65535);
      queue_random(100);
      wait_drained();

      // Principal point at the far corner, narrowest focal length: heavy clipping
      program_camera(65535, 65535, 16, 16);
      queue_pixel(4095, 4095, 65535, 24'h112233);
      queue_pixel(0, 0, 65535, 24'h445566);
      queue_random(100);
      wait_drained();

      // Zero focal length: saturate by numerator sign, zero numerator stays zero
      program_camera(2560, 2560, 0, 0);
      queue_pixel(160, 160, 1000, 24'h778899);
      queue_pixel(161, 159, 1000, 24'hAABBCC);
      queue_pixel(159, 161, 0, 24'hDDEEFF);
      queue_random(60);
      wait_drained();

      // Random camera settings
      repeat (3) begin
         program_camera($urandom_range(0, 65535), $urandom_range(0, 65535),
                        ($urandom_range(0, 1) != 0) ? $urandom_range(16, 65535)
                                                    : $urandom_range(16, 2048),
                        ($urandom_range(0, 1) != 0) ? $urandom_range(16, 65535)
                                                    : $urandom_range(16, 2048));
         queue_random(120);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_points.size() != 0)
         report_mismatch("points never delivered", 0, pending_points.size());

      $display("Back-projected %0d pixels under %0d camera settings: %0d clipped, %0d zero depth.",
               pixels_taken, camera_settings, clipped_points, zero_depth_points);
      $display("Input held by the unit for %0d cycles; %0d mismatches.",
               input_held_cycles, mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
